/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hw/rtl/erle_pkg.sv */
package erle_pkg;

	localparam logic [7:0] ESC_FIRST  = 8'h81;
	localparam logic [7:0] ESC_SECOND = 8'h82;

	// escape mode codes
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_ESC1 = 2'd1;
	localparam logic [1:0] MODE_ESC2 = 2'd2;

	// stream status codes
	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;

	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		logic [7:0] val;
		logic [7:0] cnt;
	} erle_result_t;

	// everything one input transaction produces
	typedef struct packed {
		erle_result_t r0;
		erle_result_t r1;
		logic         two;
		logic [1:0]   status;
	} erle_job_t;

endpackage

/* hw/rtl/escape_rle_decoder.sv */
// Escape run-length decoder, one compressed byte per transaction.
// First result reaches m_axis through the job FIFO and then the output register.
// Throughput: one input per cycle while the FIFO_DEPTH-entry job queue has room;
// results leave at one per cycle while m_axis_tready is high, so two-result bytes drain at half rate.
// Reset (arst_n low, async): stream finished, out_length = 1; input is ignored
// until a transaction with first_of_stream set.
module escape_rle_decoder #(
	parameter int FIFO_DEPTH = erle_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,       // out_length
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tuser,   // first_of_stream
	input  logic        s_axis_tlast,   // last_of_stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [15:8] repeat_count
	output logic [1:0]  m_axis_tuser,   // [1:0] stream_status
	output logic        m_axis_tlast    // last_of_item
);

	logic                q_full, q_empty, push, pop;
	erle_pkg::erle_job_t push_job, head_job;

	erle_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.in_byte         (s_axis_tdata),
		.first_of_stream (s_axis_tuser),
		.last_of_stream  (s_axis_tlast),
		.q_full          (q_full),
		.push            (push),
		.push_job        (push_job)
	);

	erle_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	erle_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_job      (head_job),
		.empty         (q_empty),
		.pop           (pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_byte      (m_axis_tdata[7:0]),
		.repeat_count  (m_axis_tdata[15:8]),
		.last_of_item  (m_axis_tlast),
		.stream_status (m_axis_tuser)
	);

endmodule

/* hw/rtl/erle_front.sv */
module erle_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              first_of_stream,
	input  logic              last_of_stream,
	input  logic              q_full,
	output logic              push,
	output erle_pkg::erle_job_t push_job
);

	logic [31:0] out_length_q;
	logic [1:0]  escape_mode_q;
	logic [7:0]  saved_byte_q;
	logic [31:0] bytes_remaining_q;
	logic        finished_q;

	logic        accept, active;
	logic [31:0] rem_in, rem_n;
	logic [1:0]  mode_in, mode_n;
	logic [7:0]  saved_in, saved_n;
	logic [7:0]  cm1, run_cnt, dec;
	logic        rem_is0, rem_is1, rem_is2, run_capped;
	logic [1:0]  n;
	logic [1:0]  status;
	erle_pkg::erle_result_t r0, r1;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign active    = first_of_stream || !finished_q;

	always_comb begin
		rem_in   = first_of_stream ? out_length_q : bytes_remaining_q;
		mode_in  = first_of_stream ? erle_pkg::MODE_NONE : escape_mode_q;
		saved_in = first_of_stream ? 8'd0 : saved_byte_q;
		rem_is0  = (rem_in == 32'd0);
		rem_is1  = (rem_in == 32'd1);
		rem_is2  = (rem_in == 32'd2);
		cm1      = in_byte - 8'd1;
		run_capped = (rem_in[31:8] == 24'd0) && (rem_in[7:0] < cm1);
		run_cnt  = run_capped ? rem_in[7:0] : cm1;

		mode_n  = mode_in;
		saved_n = saved_in;
		dec     = 8'd0;
		n       = 2'd0;
		r0      = '0;
		r1      = '0;

		if (!rem_is0) begin
			unique case (mode_in)
				erle_pkg::MODE_ESC1: begin
					if (in_byte == erle_pkg::ESC_SECOND) begin
						mode_n = erle_pkg::MODE_ESC2;
					end else begin
						r0      = '{val: erle_pkg::ESC_FIRST, cnt: 8'd1};
						n       = 2'd1;
						dec     = 8'd1;
						saved_n = erle_pkg::ESC_FIRST;
						// stays in ESC1 if the new byte opens another escape
						if (!rem_is1 && !(in_byte == erle_pkg::ESC_FIRST && !rem_is2)) begin
							mode_n  = erle_pkg::MODE_NONE;
							saved_n = in_byte;
							r1      = '{val: in_byte, cnt: 8'd1};
							n       = 2'd2;
							dec     = 8'd2;
						end
					end
				end
				erle_pkg::MODE_ESC2: begin
					mode_n = erle_pkg::MODE_NONE;
					if (in_byte != 8'd0) begin
						if (run_cnt != 8'd0) begin
							r0  = '{val: saved_in, cnt: run_cnt};
							n   = 2'd1;
							dec = run_cnt;
						end
					end else begin
						// escaped literal pair
						r0  = '{val: erle_pkg::ESC_FIRST, cnt: 8'd1};
						n   = 2'd1;
						dec = 8'd1;
						if (!rem_is1) begin
							saved_n = erle_pkg::ESC_SECOND;
							r1      = '{val: erle_pkg::ESC_SECOND, cnt: 8'd1};
							n       = 2'd2;
							dec     = 8'd2;
						end
					end
				end
				default: begin
					// no escape pending; unused code 3 lands here too
					if (in_byte == erle_pkg::ESC_FIRST && !rem_is1) begin
						mode_n = erle_pkg::MODE_ESC1;
					end else begin
						mode_n  = erle_pkg::MODE_NONE;
						saved_n = in_byte;
						r0      = '{val: in_byte, cnt: 8'd1};
						n       = 2'd1;
						dec     = 8'd1;
					end
				end
			endcase
		end

		rem_n = rem_in - {24'd0, dec};
		priority if (rem_in == {24'd0, dec}) status = erle_pkg::ST_DONE;
		else if (last_of_stream)             status = erle_pkg::ST_SHORT;
		else                                 status = erle_pkg::ST_RUN;

		// status-only result
		if (status != erle_pkg::ST_RUN && n == 2'd0) begin
			r0 = '0;
			n  = 2'd1;
		end

		push_job.r0     = r0;
		push_job.r1     = r1;
		push_job.two    = (n == 2'd2);
		push_job.status = status;
		push            = accept && active && (n != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_length_q      <= 32'd1;
			escape_mode_q     <= erle_pkg::MODE_NONE;
			saved_byte_q      <= 8'd0;
			bytes_remaining_q <= 32'd0;
			finished_q        <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				out_length_q <= cfg_data;
			end
			if (accept && active) begin
				escape_mode_q     <= mode_n;
				saved_byte_q      <= saved_n;
				bytes_remaining_q <= rem_n;
				finished_q        <= (status != erle_pkg::ST_RUN);
			end
		end
	end

endmodule

/* hw/rtl/erle_fifo.sv */
module erle_fifo #(
	parameter int DEPTH = erle_pkg::FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  erle_pkg::erle_job_t push_job,
	input  logic                pop,
	output erle_pkg::erle_job_t head_job,
	output logic                full,
	output logic                empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	erle_pkg::erle_job_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

endmodule

/* hw/rtl/erle_back.sv */
module erle_back (
	input  logic                clk,
	input  logic                arst_n,
	input  erle_pkg::erle_job_t head_job,
	input  logic                empty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic [7:0]          repeat_count,
	output logic                last_of_item,
	output logic [1:0]          stream_status
);

	logic                   out_valid_q;
	erle_pkg::erle_result_t out_res_q;
	logic                   out_last_q;
	logic [1:0]             out_status_q;
	logic                   pend_q;
	erle_pkg::erle_result_t pend_res_q;
	logic [1:0]             pend_status_q;
	logic                   load;

	assign load = !out_valid_q || out_ready;
	// second result of a job waits in the pending slot
	assign pop  = load && !pend_q && !empty;

	assign out_valid     = out_valid_q;
	assign out_byte      = out_res_q.val;
	assign repeat_count  = out_res_q.cnt;
	assign last_of_item  = out_last_q;
	assign stream_status = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load) begin
			out_valid_q <= pend_q || !empty;
			if (pend_q) begin
				pend_q <= 1'b0;
			end else if (!empty) begin
				pend_q <= head_job.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_res_q    <= pend_res_q;
				out_last_q   <= 1'b1;
				out_status_q <= pend_status_q;
			end else if (!empty) begin
				out_res_q     <= head_job.r0;
				out_last_q    <= !head_job.two;
				out_status_q  <= head_job.two ? erle_pkg::ST_RUN : head_job.status;
				pend_res_q    <= head_job.r1;
				pend_status_q <= head_job.status;
			end
		end
	end

endmodule

/* hw/rtl/erle_checker.sv */
`include "assert_macros.svh"

module erle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// stalled result holds
	`ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
	// a status-only result always closes its transaction
	`ASSERT_IMPL(a_status_only_last, m_axis_tvalid && m_axis_tdata[15:8] == 8'd0, m_axis_tlast)
	// status is reported only on the final result
	`ASSERT_IMPL(a_status_on_last, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == 2'd0)
	`ASSERT_IMPL(a_status_code, m_axis_tvalid, m_axis_tuser != 2'd3)
	// runs never exceed 254
	`ASSERT_IMPL(a_count_range, m_axis_tvalid, m_axis_tdata[15:8] != 8'hff)

endmodule

bind escape_rle_decoder erle_checker u_erle_checker (.*);
